// ===== sv/sfce_pkg.sv =====
// Shared constants and types for the serial-flash command engine.
package sfce_pkg;

    // Store and register widths
    localparam int ADDR_BITS  = 18;
    localparam int FADDR_BITS = 24;
    localparam int DATA_BITS  = 8;
    localparam int POS_BITS   = 3;

    // Command codes
    localparam logic [DATA_BITS-1:0] CMD_READ  = 8'h03;
    localparam logic [DATA_BITS-1:0] CMD_WRDI  = 8'h04;
    localparam logic [DATA_BITS-1:0] CMD_RDSR  = 8'h05;
    localparam logic [DATA_BITS-1:0] CMD_WREN  = 8'h06;
    localparam logic [DATA_BITS-1:0] CMD_WRITE = 8'h0A;
    localparam logic [DATA_BITS-1:0] CMD_RDID  = 8'h9F;

    // Identification bytes
    localparam logic [DATA_BITS-1:0] ID_BYTE0 = 8'h20;
    localparam logic [DATA_BITS-1:0] ID_BYTE1 = 8'h40;
    localparam logic [DATA_BITS-1:0] ID_BYTE2 = 8'h12;

    // Byte positions within a transfer
    localparam logic [POS_BITS-1:0] POS_FIRST    = 3'd1;
    localparam logic [POS_BITS-1:0] POS_ID1      = 3'd2;
    localparam logic [POS_BITS-1:0] POS_ID2      = 3'd3;
    localparam logic [POS_BITS-1:0] POS_DATA     = 3'd4;
    localparam logic [POS_BITS-1:0] POS_SATURATE = 3'd7;

    // Per-request memory access and result information
    typedef struct packed {
        logic                 mem_we;
        logic                 mem_re;
        logic [ADDR_BITS-1:0] mem_addr;
        logic [DATA_BITS-1:0] mem_wdata;
        logic                 use_mem;
        logic [DATA_BITS-1:0] value;
    } t_req;

endpackage

// ===== sv/sfce_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module sfce_ram #(
    parameter int AW = 10,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(1<<AW)-1];
    logic [DW-1:0] r_rdata;

    // Write or read one entry per cycle; hold read data otherwise
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sfce_ctrl.sv =====
// Command decode and transfer registers; issues store accesses per request.
module sfce_ctrl
    import sfce_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  logic [DATA_BITS-1:0] i_data_in,
    input  logic                 i_keep_select,
    output t_req                 o_req
);

    logic                  r_in_cmd, n_in_cmd;
    logic [DATA_BITS-1:0]  r_cmd, n_cmd;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [FADDR_BITS-1:0] r_addr, n_addr;
    logic                  r_wen, n_wen;
    t_req                  req;

    // Decode the request against the open transfer
    always_comb begin
        n_in_cmd      = r_in_cmd;
        n_cmd         = r_cmd;
        n_pos         = r_pos;
        n_addr        = r_addr;
        n_wen         = r_wen;
        req.mem_we    = 1'b0;
        req.mem_re    = 1'b0;
        req.mem_addr  = r_addr[ADDR_BITS-1:0];
        req.mem_wdata = i_data_in;
        req.use_mem   = 1'b0;
        req.value     = '0;
        if (!r_in_cmd) begin
            n_in_cmd = 1'b1;
            n_cmd    = i_data_in;
            n_pos    = POS_FIRST;
            n_addr   = '0;
            if (i_data_in == CMD_WRDI) begin
                n_wen = 1'b0;
            end else if (i_data_in == CMD_WREN) begin
                n_wen = 1'b1;
            end
        end else begin
            case (r_cmd)
                CMD_RDSR: begin
                    req.value = {6'b0, r_wen, 1'b0};
                end
                CMD_RDID: begin
                    if (r_pos == POS_FIRST) begin
                        req.value = ID_BYTE0;
                    end else if (r_pos == POS_ID1) begin
                        req.value = ID_BYTE1;
                    end else if (r_pos == POS_ID2) begin
                        req.value = ID_BYTE2;
                    end
                    if (r_pos != POS_SATURATE) begin
                        n_pos = r_pos + 3'd1;
                    end
                end
                CMD_READ, CMD_WRITE: begin
                    if (r_pos < POS_DATA) begin
                        n_addr = {r_addr[FADDR_BITS-DATA_BITS-1:0], i_data_in};
                    end else begin
                        if (r_cmd == CMD_READ) begin
                            req.mem_re  = 1'b1;
                            req.use_mem = 1'b1;
                        end else begin
                            req.mem_we = 1'b1;
                            req.value  = i_data_in;
                        end
                        n_addr = r_addr + 24'd1;
                    end
                    if (r_pos != POS_SATURATE) begin
                        n_pos = r_pos + 3'd1;
                    end
                end
                default: begin
                    req.value = '0;
                end
            endcase
        end
        // Drop the command on release of chip select
        if (!i_keep_select) begin
            n_in_cmd = 1'b0;
            n_cmd    = '0;
        end
    end

    // Advance transfer state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cmd <= 1'b0;
            r_cmd    <= '0;
            r_pos    <= '0;
            r_addr   <= '0;
            r_wen    <= 1'b0;
        end else if (i_acc) begin
            r_in_cmd <= n_in_cmd;
            r_cmd    <= n_cmd;
            r_pos    <= n_pos;
            r_addr   <= n_addr;
            r_wen    <= n_wen;
        end
    end

    // Gate store accesses with the accept
    always_comb begin
        o_req        = req;
        o_req.mem_we = req.mem_we & i_acc;
        o_req.mem_re = req.mem_re & i_acc;
    end

endmodule

// ===== sv/spi_flash_command_engine_core.sv =====
// Serial-flash command engine: request pipeline, store and result register.
// Path: an accepted request passes through stage 1, then the result register that drives o_valid.
// Throughput: one request per cycle while o_stall is low; each data byte makes one access to the
// single-port store, whose read data is registered.
// Reset: synchronous active-low i_rst_n clears command, position, address,
// status and pipeline valids; store contents are undefined until written.
module spi_flash_command_engine_core
    import sfce_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [DATA_BITS-1:0] i_data_in,
    input  logic                 i_keep_select,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DATA_BITS-1:0] o_data_out
);

    t_req                 req;
    logic [DATA_BITS-1:0] mem_rdata;
    logic                 in_acc;
    logic                 s1_adv;
    logic                 r_s1_valid;
    logic                 r_s1_use_mem;
    logic [DATA_BITS-1:0] r_s1_value;
    logic                 r_out_valid;
    logic [DATA_BITS-1:0] r_out_data;

    // Move stage 1 forward when the result register is free or being taken
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    sfce_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (in_acc),
        .i_data_in     (i_data_in),
        .i_keep_select (i_keep_select),
        .o_req         (req)
    );

    sfce_ram #(
        .AW (ADDR_BITS),
        .DW (DATA_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (req.mem_we),
        .i_re    (req.mem_re),
        .i_addr  (req.mem_addr),
        .i_wdata (req.mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Stage 1: hold the request result while the store read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_use_mem <= req.use_mem;
            r_s1_value   <= req.value;
        end
    end

    // Result register: load from stage 1, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= r_s1_use_mem ? mem_rdata : r_s1_value;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_data_out = r_out_data;

    // Every accepted request lands in stage 1
    a_acc_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted request did not reach stage 1");

    // A blocked stage 1 keeps its result
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_value)
                                     && $stable(r_s1_use_mem)))
        else $error("stage 1 result lost while blocked");

    // A held store read is not overwritten by a new read
    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv && r_s1_use_mem) |-> !req.mem_re)
        else $error("store read issued while earlier read data pending");

    // Store never reads and writes in the same cycle
    a_mem_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req.mem_we && req.mem_re))
        else $error("store read and write in one cycle");

endmodule
